// ----- hw/rtl/eit_pkg.sv -----
// eit_pkg: shared types, codes and constants of the event interest table
`timescale 1ns / 1ps

package eit_pkg;

  localparam int EIT_INSTANCES = 16;
  localparam int EIT_ENTRIES   = 64;

  localparam logic [15:0] HANDLE_BASE = 16'h4000;
  localparam logic [2:0]  EV_IN       = 3'h1;
  localparam logic [2:0]  EV_OUT      = 3'h4;
  localparam logic [2:0]  EV_MASK     = EV_IN | EV_OUT;
  localparam logic [6:0]  MAX_REPORT  = 7'd64;

  // request function codes
  localparam logic [2:0] FUNC_CREATE = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_MODIFY = 3'd3;
  localparam logic [2:0] FUNC_WAIT   = 3'd4;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADF   = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOINST = 3'd3,
    ST_INVAL  = 3'd4
  } eit_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_COUNT,
    S_SCAN,
    S_MOVE,
    S_WAIT,
    S_RESP
  } eit_state_t;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_ZERO = 2'd1,
    POS_INC  = 2'd2,
    POS_LAST = 2'd3
  } eit_pos_sel_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] instance_handle;
    logic [15:0] fd;
    logic        has_event;
    logic [31:0] event_mask;
    logic [63:0] entry_data;
    logic [6:0]  max_events;
  } eit_in_t;

  typedef struct packed {
    eit_status_t status;
    logic [15:0] new_handle;
    logic [2:0]  ready_mask;
    logic [63:0] ready_data;
    logic [6:0]  reported_count;
    logic        last;
  } eit_out_t;

  typedef struct packed {
    logic         load_req;
    logic         resp_set;
    eit_status_t  resp_code;
    logic         alloc;
    logic         add_write;
    logic         mod_write;
    logic         hit_save;
    logic         move_write;
    logic         lim_load;
    eit_pos_sel_t pos_sel;
    logic         push_resp;
    logic         push_wait;
  } eit_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       handle_ok;
    logic       maxev_zero;
    logic       inst_avail;
    logic       list_full;
    logic       cnt_zero;
    logic       lim_zero;
    logic       fd_match;
    logic       scan_end;
    logic       wait_last;
    logic       slot_free;
  } eit_sts_t;

endpackage

// ----- hw/rtl/eit_ctrl.sv -----
// eit_ctrl: request sequencer of the event interest table
`timescale 1ns / 1ps

module eit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  eit_pkg::eit_sts_t sts,
  output eit_pkg::eit_cmd_t cmd
);
  import eit_pkg::*;

  eit_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.func)
          FUNC_CREATE: begin
            cmd.resp_set = 1'b1;
            if (sts.inst_avail) begin
              cmd.alloc     = 1'b1;
              cmd.resp_code = ST_OK;
            end else begin
              cmd.resp_code = ST_NOINST;
            end
            state_nxt = S_RESP;
          end
          FUNC_WAIT: begin
            if (sts.maxev_zero) begin
              cmd.resp_set  = 1'b1;
              cmd.resp_code = ST_INVAL;
              state_nxt     = S_RESP;
            end else if (!sts.handle_ok) begin
              cmd.resp_set  = 1'b1;
              cmd.resp_code = ST_BADF;
              state_nxt     = S_RESP;
            end else begin
              state_nxt = S_COUNT;
            end
          end
          default: begin
            if (!sts.handle_ok) begin
              cmd.resp_set  = 1'b1;
              cmd.resp_code = ST_BADF;
              state_nxt     = S_RESP;
            end else begin
              state_nxt = S_COUNT;
            end
          end
        endcase
      end
      S_COUNT: begin
        case (sts.func)
          FUNC_ADD: begin
            cmd.resp_set = 1'b1;
            if (sts.list_full) begin
              cmd.resp_code = ST_FULL;
            end else begin
              cmd.add_write = 1'b1;
              cmd.resp_code = ST_OK;
            end
            state_nxt = S_RESP;
          end
          FUNC_DELETE, FUNC_MODIFY: begin
            if (sts.cnt_zero) begin
              cmd.resp_set = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              cmd.pos_sel = POS_ZERO;
              state_nxt   = S_SCAN;
            end
          end
          FUNC_WAIT: begin
            cmd.lim_load = 1'b1;
            if (sts.lim_zero) begin
              cmd.resp_set = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              cmd.pos_sel = POS_ZERO;
              state_nxt   = S_WAIT;
            end
          end
          default: begin
            cmd.resp_set = 1'b1;
            state_nxt    = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.fd_match) begin
          if (sts.func == FUNC_DELETE) begin
            cmd.hit_save = 1'b1;
            cmd.pos_sel  = POS_LAST;
            state_nxt    = S_MOVE;
          end else begin
            cmd.mod_write = 1'b1;
            cmd.resp_set  = 1'b1;
            state_nxt     = S_RESP;
          end
        end else if (sts.scan_end) begin
          cmd.resp_set = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.pos_sel = POS_INC;
        end
      end
      S_MOVE: begin
        cmd.move_write = 1'b1;
        cmd.resp_set   = 1'b1;
        state_nxt      = S_RESP;
      end
      S_WAIT: begin
        if (sts.slot_free) begin
          cmd.push_wait = 1'b1;
          if (sts.wait_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pos_sel = POS_INC;
          end
        end
      end
      S_RESP: begin
        if (sts.slot_free) begin
          cmd.push_resp = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/eit_dp.sv -----
// eit_dp: request register, instance and entry stores, result register
`timescale 1ns / 1ps

module eit_dp #(
  parameter int INSTANCES = eit_pkg::EIT_INSTANCES,
  parameter int ENTRIES   = eit_pkg::EIT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  eit_pkg::eit_cmd_t cmd,
  output eit_pkg::eit_sts_t sts,
  input  eit_pkg::eit_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output eit_pkg::eit_out_t out_data
);
  import eit_pkg::*;

  localparam int IW    = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam int AW    = $clog2(INSTANCES + 1);
  localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int SW    = ((CW > EW) ? CW : EW) + 1;
  localparam int MW    = $bits(in_data.max_events);
  localparam int LW    = (CW > MW) ? CW : MW;
  localparam int DEPTH = INSTANCES * (2 ** EW);

  eit_in_t     req_r;
  logic [AW-1:0] alloc_r;
  logic [EW-1:0] pos_r, pos_nxt, hit_r;
  logic [6:0]  lim_r;
  logic [LW-1:0] lim_nxt, lim_a;
  eit_status_t resp_status_r;
  logic [15:0] resp_handle_r;
  eit_out_t    out_data_r;
  logic        out_valid_r;

  logic [15:0]   off;
  logic [IW-1:0] idx;
  logic [6:0]    rep;

  // entry stores, addressed by {instance, slot}; counts addressed by instance
  logic [15:0]   fd_mem   [DEPTH];
  logic [2:0]    mask_mem [DEPTH];
  logic [63:0]   data_mem [DEPTH];
  logic [CW-1:0] cnt_mem  [INSTANCES];

  logic [15:0]   fd_q;
  logic [2:0]    mask_q;
  logic [63:0]   data_q;
  logic [CW-1:0] cnt_q;

  logic [IW+EW-1:0] rd_addr, wr_addr;
  logic [15:0]      wr_fd;
  logic [2:0]       wr_mask, new_mask;
  logic [63:0]      wr_data, new_data;
  logic             ent_we, fd_we;
  logic             cnt_we;
  logic [IW-1:0]    cnt_waddr;
  logic [CW-1:0]    cnt_wdata;

  assign off = req_r.instance_handle - HANDLE_BASE;
  assign idx = off[IW-1:0];

  always_comb begin
    case (cmd.pos_sel)
      POS_ZERO: pos_nxt = '0;
      POS_INC:  pos_nxt = pos_r + 1'b1;
      POS_LAST: pos_nxt = EW'(cnt_q - CW'(1));
      default:  pos_nxt = pos_r;
    endcase
  end

  // the read address follows pos_nxt, so the registered read data always belongs to pos_r
  assign rd_addr = {idx, pos_nxt};

  assign new_mask = req_r.has_event ? (req_r.event_mask[2:0] & EV_MASK) : EV_MASK;
  assign new_data = req_r.has_event ? req_r.entry_data : 64'd0;

  always_comb begin
    if (cmd.move_write) begin
      wr_addr = {idx, hit_r};
    end else if (cmd.mod_write) begin
      wr_addr = {idx, pos_r};
    end else begin
      wr_addr = {idx, EW'(cnt_q)};
    end
    wr_fd   = cmd.move_write ? fd_q   : req_r.fd;
    wr_mask = cmd.move_write ? mask_q : new_mask;
    wr_data = cmd.move_write ? data_q : new_data;
  end

  assign fd_we  = cmd.add_write | cmd.move_write;
  assign ent_we = cmd.add_write | cmd.move_write | cmd.mod_write;

  always_ff @(posedge clk) begin
    if (fd_we) begin
      fd_mem[wr_addr] <= wr_fd;
    end
    if (ent_we) begin
      mask_mem[wr_addr] <= wr_mask;
      data_mem[wr_addr] <= wr_data;
    end
    fd_q   <= fd_mem[rd_addr];
    mask_q <= mask_mem[rd_addr];
    data_q <= data_mem[rd_addr];
  end

  always_comb begin
    cnt_we    = cmd.alloc | cmd.add_write | cmd.move_write;
    cnt_waddr = cmd.alloc ? alloc_r[IW-1:0] : idx;
    if (cmd.alloc) begin
      cnt_wdata = '0;
    end else if (cmd.add_write) begin
      cnt_wdata = cnt_q + CW'(1);
    end else begin
      cnt_wdata = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[idx];
  end

  // instances are claimed in order and never released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
    end else if (cmd.alloc) begin
      alloc_r <= alloc_r + 1'b1;
    end
  end

  always_comb begin
    lim_a   = (LW'(cnt_q) < LW'(req_r.max_events)) ? LW'(cnt_q) : LW'(req_r.max_events);
    lim_nxt = (lim_a < LW'(MAX_REPORT)) ? lim_a : LW'(MAX_REPORT);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    pos_r <= pos_nxt;
    if (cmd.hit_save) begin
      hit_r <= pos_r;
    end
    if (cmd.lim_load) begin
      lim_r <= 7'(lim_nxt);
    end
    if (cmd.resp_set) begin
      resp_status_r <= cmd.resp_code;
      resp_handle_r <= cmd.alloc ? (HANDLE_BASE + 16'(alloc_r)) : 16'd0;
    end
  end

  assign rep = 7'(pos_r) + 7'd1;

  always_comb begin
    sts            = '0;
    sts.func       = req_r.func;
    sts.handle_ok  = (req_r.instance_handle >= HANDLE_BASE) && (off < 16'(alloc_r));
    sts.maxev_zero = (req_r.max_events == '0);
    sts.inst_avail = (alloc_r < AW'(INSTANCES));
    sts.list_full  = (cnt_q >= CW'(ENTRIES));
    sts.cnt_zero   = (cnt_q == '0);
    sts.lim_zero   = (lim_nxt == '0);
    sts.fd_match   = (fd_q == req_r.fd);
    sts.scan_end   = ((SW'(pos_r) + SW'(1)) == SW'(cnt_q));
    sts.wait_last  = (rep == lim_r);
    sts.slot_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_resp || cmd.push_wait) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_resp) begin
      out_data_r <= '{status: resp_status_r, new_handle: resp_handle_r, ready_mask: 3'd0,
                      ready_data: 64'd0, reported_count: 7'd0, last: 1'b1};
    end else if (cmd.push_wait) begin
      out_data_r <= '{status: ST_OK, new_handle: 16'd0, ready_mask: mask_q,
                      ready_data: data_q, reported_count: rep, last: sts.wait_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/event_interest_table_top.sv -----
// event_interest_table_top: pool of epoll-style interest lists, top level
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// in_       in   in_valid/in_ready    eit_in_t  (func, handle, fd, event, max_events)
// out_      out  out_valid/out_ready  eit_out_t (status, handle, mask, data, count, last)
//
// one request is worked on at a time; create and requests refused by the first
// check go from the check state straight to the result; add and unknown requests
// also pass the count state; delete and modify then walk the list, comparing
// one entry per step (delete then moves the last entry into the freed slot);
// wait gives one result per cycle unless out_ready stalls. the single read port
// of the entry store sets the walk rate. synchronous active-low reset clears
// control only, entry stores stay undefined and no clearing pass runs; an
// instance's count is written when it is created. a stalled out_ready holds
// the result register and the walk, and the next request is accepted while
// the last result still waits

module event_interest_table_top #(
  parameter int INSTANCES = eit_pkg::EIT_INSTANCES,
  parameter int ENTRIES   = eit_pkg::EIT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  eit_pkg::eit_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output eit_pkg::eit_out_t out_data
);
  import eit_pkg::*;

  // command and status between sequencer and datapath
  eit_cmd_t cmd;
  eit_sts_t sts;

  // sequencer: lookup, list walk and result pacing
  eit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: request register, stores, output register
  eit_dp #(
    .INSTANCES (INSTANCES),
    .ENTRIES   (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a result is only loaded into a free output slot
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_resp || cmd.push_wait) |-> sts.slot_free)
    else $error("result pushed into an occupied output register");

  // single results and walk results never collide
  a_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push_resp && cmd.push_wait))
    else $error("two result sources in one cycle");

  // output only becomes valid after a push
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.push_resp || cmd.push_wait))
    else $error("output valid without a pushed result");

  // a request is worked on alone
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule
